// File: rtl/core/npcs_pkg.sv
// Shared types and constants for the nearest point cut-off search block.
package npcs_pkg;

  // Pattern positions saturate at the last index of the pattern store range.
  localparam int unsigned MaxPoints = 1024;
  localparam int unsigned IndexW    = 10;
  localparam logic [IndexW-1:0] LastPos = IndexW'(MaxPoints - 1);

  // Coordinate, penalty and distance widths.
  localparam int unsigned CoordW = 16;
  localparam int unsigned PenW   = 32;
  localparam int unsigned SqW    = 2 * CoordW;
  localparam int unsigned DistW  = PenW + 1;
  localparam int unsigned BestW  = DistW + 1;

  // Configuration port geometry and register word indexes.
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;
  localparam logic [1:0] RegQueryX       = 2'd0;
  localparam logic [1:0] RegQueryY       = 2'd1;
  localparam logic [1:0] RegQueryMissing = 2'd2;
  localparam logic [1:0] RegPenaltyPower = 2'd3;

  // Match kind codes reported with each result.
  localparam logic [1:0] KindMissing = 2'd0;
  localparam logic [1:0] KindCutoff  = 2'd1;
  localparam logic [1:0] KindProper  = 2'd2;

  // One pattern point as it arrives on the input channel.
  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     point_missing;
    logic                     last_point;
  } point_t;

  // One search result as it leaves on the output channel.
  typedef struct packed {
    logic [IndexW-1:0] nearest_index;
    logic [1:0]        match_kind;
  } result_t;

endpackage

// File: rtl/core/nearest_point_cutoff_search.sv
// Top level of the nearest point cut-off search: point pipeline, running minimum, APB registers.
// A result reaches the output register after its last point passes stage A and stage B.
// One point per cycle unless stalled; the running-minimum register update is the single loop.
// A stalled result blocks the pipeline only when a second last point reaches the update stage.
// Reset clears the registers, the pipeline valids and the search state (best distance infinite).
module nearest_point_cutoff_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Point input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  npcs_pkg::point_t              in_data_i,
  // Result output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output npcs_pkg::result_t             out_data_o,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [npcs_pkg::AddrW-1:0]    paddr,
  input  logic [npcs_pkg::DataW-1:0]    pwdata,
  output logic [npcs_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  // Configuration registers
  logic signed [npcs_pkg::CoordW-1:0] query_x_q;
  logic signed [npcs_pkg::CoordW-1:0] query_y_q;
  logic                               query_missing_q;
  logic [npcs_pkg::PenW-1:0]          penalty_q;
  logic                               cfg_write;

  // Stage A: registered input point
  logic             a_vld_q;
  npcs_pkg::point_t a_pt_q;
  logic             a_ready;

  // Stage B: registered squares and flags
  logic                         b_vld_q;
  logic [npcs_pkg::SqW-1:0]     b_sqx_q;
  logic [npcs_pkg::SqW-1:0]     b_sqy_q;
  logic                         b_pmiss_q;
  logic                         b_last_q;
  logic                         b_go;
  logic                         b_ready;

  // Search state
  logic [npcs_pkg::BestW-1:0]   best_dist_q;
  logic [npcs_pkg::IndexW-1:0]  best_pos_q;
  logic                         best_miss_q;
  logic [npcs_pkg::IndexW-1:0]  cnt_q;

  // Output register
  logic                 out_vld_q;
  npcs_pkg::result_t    out_data_q;
  logic                 out_free;

  // Distance datapath
  logic signed [npcs_pkg::CoordW:0] dx;
  logic signed [npcs_pkg::CoordW:0] dy;
  logic [npcs_pkg::CoordW:0]        adx;
  logic [npcs_pkg::CoordW:0]        ady;
  logic [npcs_pkg::CoordW-1:0]      ax;
  logic [npcs_pkg::CoordW-1:0]      ay;
  logic [npcs_pkg::SqW-1:0]         sqx;
  logic [npcs_pkg::SqW-1:0]         sqy;
  logic [npcs_pkg::DistW-1:0]       sum;
  logic [npcs_pkg::DistW-1:0]       cap;
  logic [npcs_pkg::DistW-1:0]       capped;
  logic [npcs_pkg::DistW-1:0]       pt_dist;
  logic                             take;
  logic [npcs_pkg::BestW-1:0]       nb_dist;
  logic [npcs_pkg::IndexW-1:0]      nb_pos;
  logic                             nb_miss;
  logic [1:0]                       kind;

  // The APB port never waits; a write lands on the access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_x_q       <= '0;
      query_y_q       <= '0;
      query_missing_q <= 1'b0;
      penalty_q       <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        npcs_pkg::RegQueryX:       query_x_q       <= pwdata[npcs_pkg::CoordW-1:0];
        npcs_pkg::RegQueryY:       query_y_q       <= pwdata[npcs_pkg::CoordW-1:0];
        npcs_pkg::RegQueryMissing: query_missing_q <= pwdata[0];
        npcs_pkg::RegPenaltyPower: penalty_q       <= pwdata[npcs_pkg::PenW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      npcs_pkg::RegQueryX:       prdata = {16'b0, query_x_q};
      npcs_pkg::RegQueryY:       prdata = {16'b0, query_y_q};
      npcs_pkg::RegQueryMissing: prdata = {31'b0, query_missing_q};
      npcs_pkg::RegPenaltyPower: prdata = penalty_q;
      default:                   prdata = '0;
    endcase
  end

  // Flow control: a stage moves when the one after it is empty or moving.
  assign out_free   = !out_vld_q || out_ready_i;
  assign b_go       = b_vld_q && (!b_last_q || out_free);
  assign b_ready    = !b_vld_q || b_go;
  assign a_ready    = !a_vld_q || b_ready;
  assign in_ready_o = a_ready;

  // Stage A captures each transfer on the input channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (a_ready) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_pt_q <= in_data_i;
    end
  end

  // Absolute coordinate differences and their squares.
  assign dx  = {query_x_q[npcs_pkg::CoordW-1], query_x_q}
             - {a_pt_q.point_x[npcs_pkg::CoordW-1], a_pt_q.point_x};
  assign dy  = {query_y_q[npcs_pkg::CoordW-1], query_y_q}
             - {a_pt_q.point_y[npcs_pkg::CoordW-1], a_pt_q.point_y};
  assign adx = dx[npcs_pkg::CoordW] ? 17'(-dx) : 17'(dx);
  assign ady = dy[npcs_pkg::CoordW] ? 17'(-dy) : 17'(dy);
  assign ax  = adx[npcs_pkg::CoordW-1:0];
  assign ay  = ady[npcs_pkg::CoordW-1:0];
  assign sqx = {16'b0, ax} * {16'b0, ax};
  assign sqy = {16'b0, ay} * {16'b0, ay};

  // Stage B holds the squares until the update stage takes them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (b_ready) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_vld_q) begin
      b_sqx_q   <= sqx;
      b_sqy_q   <= sqy;
      b_pmiss_q <= a_pt_q.point_missing;
      b_last_q  <= a_pt_q.last_point;
    end
  end

  // Distance under the missing-point rules, capped at twice the penalty.
  assign sum    = {1'b0, b_sqx_q} + {1'b0, b_sqy_q};
  assign cap    = {penalty_q, 1'b0};
  assign capped = (sum < cap) ? sum : cap;

  always_comb begin
    if (b_pmiss_q && query_missing_q) begin
      pt_dist = '0;
    end else if (b_pmiss_q || query_missing_q) begin
      pt_dist = {1'b0, penalty_q};
    end else begin
      pt_dist = capped;
    end
  end

  // Running minimum; a tie keeps the earlier point.
  assign take    = {1'b0, pt_dist} < best_dist_q;
  assign nb_dist = take ? {1'b0, pt_dist} : best_dist_q;
  assign nb_pos  = take ? cnt_q : best_pos_q;
  assign nb_miss = take ? b_pmiss_q : best_miss_q;

  // Match kind of the pattern that ends with this point.
  always_comb begin
    if (nb_miss) begin
      kind = npcs_pkg::KindMissing;
    end else if (nb_dist == {1'b0, cap} || query_missing_q) begin
      kind = npcs_pkg::KindCutoff;
    end else begin
      kind = npcs_pkg::KindProper;
    end
  end

  // Search state update; the last point of a pattern starts a fresh search.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_dist_q <= '1;
      best_pos_q  <= '0;
      best_miss_q <= 1'b0;
      cnt_q       <= '0;
    end else if (b_go) begin
      if (b_last_q) begin
        best_dist_q <= '1;
        best_pos_q  <= '0;
        best_miss_q <= 1'b0;
        cnt_q       <= '0;
      end else begin
        best_dist_q <= nb_dist;
        best_pos_q  <= nb_pos;
        best_miss_q <= nb_miss;
        if (cnt_q != npcs_pkg::LastPos) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  // Output register holds a result until its transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (b_go && b_last_q) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_go && b_last_q) begin
      out_data_q.nearest_index <= nb_pos;
      out_data_q.match_kind    <= kind;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

endmodule
